FILE: rtl/core/ll1_pkg.sv
// ----------------------------------------------------------------------------
// ll1_pkg
// Types, codes and defaults shared by the predictive parse engine.
// ----------------------------------------------------------------------------
package ll1_pkg;

    localparam int STACK_DEPTH_D       = 64;
    localparam int TERMINAL_COUNT_D    = 64;
    localparam int NONTERMINAL_COUNT_D = 64;
    localparam int PRODUCTION_COUNT_D  = 256;
    localparam int MAX_PROD_LEN_D      = 8;
    localparam int EXPANSION_LIMIT     = 62;

    localparam logic [6:0] START_SYMBOL_RST = 7'd64;

    localparam logic [2:0] OP_TABLE = 3'd0;
    localparam logic [2:0] OP_PSYM  = 3'd1;
    localparam logic [2:0] OP_PLEN  = 3'd2;
    localparam logic [2:0] OP_START = 3'd3;
    localparam logic [2:0] OP_TOKEN = 3'd4;

    localparam logic [2:0] K_DONE     = 3'd0;
    localparam logic [2:0] K_EXPANDED = 3'd1;
    localparam logic [2:0] K_MATCHED  = 3'd2;
    localparam logic [2:0] K_ERROR    = 3'd3;
    localparam logic [2:0] K_ACCEPT   = 3'd4;
    localparam logic [2:0] K_REJECT   = 3'd5;

    typedef struct packed {
        logic [2:0] operation;
        logic [5:0] nonterminal_index;
        logic [5:0] terminal_code;
        logic [7:0] production_index;
        logic       entry_valid;
        logic [2:0] position;
        logic [6:0] symbol_code;
        logic [3:0] length;
        logic       token_is_end;
    } t_req;

    typedef struct packed {
        logic [2:0] kind;
        logic [7:0] used_production;
        logic       last;
    } t_res;

    // controller to datapath
    typedef struct packed {
        logic load;       // capture request
        logic wr_table;
        logic wr_psym;
        logic wr_plen;
        logic start;
        logic rd_top;     // read stack top
        logic rd_cell;    // read table cell for the top
        logic rd_len;     // read production length
        logic pop;
        logic push;       // push one symbol (reverse order)
        logic exp_begin;  // pop nonterminal, set push count
        logic clr_exp;
        logic end_parse;
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic clearing;   // table clear after reset
        logic active;
        logic is_token;
        logic is_end;
        logic empty;
        logic top_term;
        logic top_match;
        logic hit;
        logic limit;      // expansion limit or overflow
        logic push_done;
        logic [7:0] prod;
    } t_sts;

endpackage

FILE: rtl/core/ll1_datapath.sv
// ----------------------------------------------------------------------------
// ll1_datapath
// Stack, parse table and production memories with their address logic.
// ----------------------------------------------------------------------------
module ll1_datapath #(
    parameter int STACK_DEPTH       = ll1_pkg::STACK_DEPTH_D,
    parameter int TERMINAL_COUNT    = ll1_pkg::TERMINAL_COUNT_D,
    parameter int NONTERMINAL_COUNT = ll1_pkg::NONTERMINAL_COUNT_D,
    parameter int PRODUCTION_COUNT  = ll1_pkg::PRODUCTION_COUNT_D,
    parameter int MAX_PROD_LEN      = ll1_pkg::MAX_PROD_LEN_D
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  ll1_pkg::t_req i_req,
    input  logic [6:0]    i_start_symbol,
    input  ll1_pkg::t_cmd i_cmd,
    output ll1_pkg::t_sts o_sts
);
    localparam int SPW = $clog2(STACK_DEPTH + 1);
    localparam int SAW = $clog2(STACK_DEPTH);
    localparam int PW  = (PRODUCTION_COUNT > 1) ? $clog2(PRODUCTION_COUNT) : 1;
    localparam int LCW = $clog2(MAX_PROD_LEN + 1);
    localparam int NTC = (NONTERMINAL_COUNT < 64) ? NONTERMINAL_COUNT : 64;
    localparam int TC  = (TERMINAL_COUNT < 64) ? TERMINAL_COUNT : 64;
    localparam int TD  = NTC * TC;
    localparam int TAW = (TD > 1) ? $clog2(TD) : 1;
    localparam int PSD = PRODUCTION_COUNT * MAX_PROD_LEN;
    localparam int PSW = (PSD > 1) ? $clog2(PSD) : 1;

    logic [6:0]     r_stack [STACK_DEPTH];
    logic [8:0]     r_table [TD];
    logic [6:0]     r_psym [PSD];
    logic [LCW-1:0] r_plen [PRODUCTION_COUNT];

    ll1_pkg::t_req  r_req;
    logic [SPW-1:0] r_sp;
    logic           r_active;
    logic [5:0]     r_exp;
    logic [6:0]     r_top;
    logic [8:0]     r_cell;
    logic           r_row_ok;
    logic [LCW-1:0] r_len;
    logic [LCW-1:0] r_cnt;
    logic [7:0]     r_prod;
    logic [6:0]     r_sym;
    logic           r_wr_pend;
    logic           r_clearing;
    logic [TAW-1:0] r_clr_addr;

    logic [TAW-1:0] w_taddr, w_raddr, w_twaddr;
    logic           w_twen;
    logic [8:0]     w_twdata;
    logic [6:0]     w_row;
    logic [SPW:0]   w_need;
    logic [LCW-1:0] w_len_sat;
    logic [PSW-1:0] w_paddr;

    assign w_taddr = TAW'(32'(r_req.nonterminal_index) * TC + 32'(r_req.terminal_code));
    assign w_row   = r_top - 7'd64;
    assign w_raddr = TAW'(32'(w_row) * TC + 32'(r_req.terminal_code));
    assign w_len_sat = (32'(r_req.length) > MAX_PROD_LEN) ? LCW'(MAX_PROD_LEN)
                                                          : LCW'(r_req.length);
    assign w_paddr = PSW'(32'(r_prod) * MAX_PROD_LEN + 32'(r_cnt) - 1);
    assign w_need  = (SPW+1)'(r_sp) - (SPW+1)'(1) + (SPW+1)'(r_len);

    assign w_twen   = r_clearing || (i_cmd.wr_table && 32'(r_req.nonterminal_index) < NTC
                                     && 32'(r_req.terminal_code) < TC);
    assign w_twaddr = r_clearing ? r_clr_addr : w_taddr;
    assign w_twdata = r_clearing ? 9'd0 : {r_req.entry_valid, r_req.production_index};

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) r_req <= i_req;
        if (w_twen) r_table[w_twaddr] <= w_twdata;
        if (i_cmd.wr_psym && 32'(r_req.production_index) < PRODUCTION_COUNT
            && 32'(r_req.position) < MAX_PROD_LEN)
            r_psym[PSW'(32'(r_req.production_index) * MAX_PROD_LEN
                   + 32'(r_req.position))] <= r_req.symbol_code;
        if (i_cmd.wr_plen && 32'(r_req.production_index) < PRODUCTION_COUNT)
            r_plen[PW'(r_req.production_index)] <= w_len_sat;
        if (i_cmd.rd_top) r_top <= r_stack[SAW'(r_sp - SPW'(1))];
        if (i_cmd.rd_cell) begin
            r_row_ok <= 32'(w_row) < NTC;
            r_cell   <= r_table[w_raddr];
        end
        if (i_cmd.rd_len) begin
            r_prod <= r_cell[7:0];
            r_len  <= r_plen[PW'(r_cell[7:0])];
        end
        if (i_cmd.exp_begin) r_cnt <= r_len;
        else if (i_cmd.push) r_cnt <= r_cnt - LCW'(1);
        if (i_cmd.push) r_sym <= r_psym[w_paddr];
        if (i_cmd.start) r_stack[0] <= i_start_symbol;
        else if (r_wr_pend) r_stack[SAW'(r_sp)] <= r_sym;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sp       <= '0;
            r_active   <= 1'b0;
            r_exp      <= '0;
            r_wr_pend  <= 1'b0;
            r_clearing <= 1'b1;
            r_clr_addr <= '0;
        end else begin
            if (r_clearing) begin
                r_clr_addr <= r_clr_addr + TAW'(1);
                if (r_clr_addr == TAW'(TD - 1)) r_clearing <= 1'b0;
            end
            if (i_cmd.start) begin
                r_sp     <= SPW'(1);
                r_active <= 1'b1;
            end
            if (i_cmd.pop || i_cmd.exp_begin) r_sp <= r_sp - SPW'(1);
            if (r_wr_pend) r_sp <= r_sp + SPW'(1);
            r_wr_pend <= i_cmd.push;
            if (i_cmd.clr_exp) r_exp <= '0;
            if (i_cmd.exp_begin) r_exp <= r_exp + 6'd1;
            if (i_cmd.end_parse) r_active <= 1'b0;
        end
    end

    always_comb begin
        o_sts.clearing  = r_clearing;
        o_sts.active    = r_active;
        o_sts.is_token  = (r_req.operation == ll1_pkg::OP_TOKEN);
        o_sts.is_end    = r_req.token_is_end;
        o_sts.empty     = (r_sp == '0);
        o_sts.top_term  = ~r_top[6];
        o_sts.top_match = (r_top[5:0] == r_req.terminal_code);
        o_sts.hit       = r_row_ok && 32'(r_req.terminal_code) < TC
                          && r_cell[8] && 32'(r_cell[7:0]) < PRODUCTION_COUNT;
        o_sts.limit     = (32'(r_exp) >= ll1_pkg::EXPANSION_LIMIT)
                          || (32'(w_need) > STACK_DEPTH);
        o_sts.push_done = (r_cnt == '0);
        o_sts.prod      = r_prod;
    end
endmodule

FILE: rtl/core/ll1_ctrl.sv
// ----------------------------------------------------------------------------
// ll1_ctrl
// Sequencer for loads, start and token expansion; drives the result strobe.
// ----------------------------------------------------------------------------
module ll1_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  logic [2:0]    i_op,
    input  ll1_pkg::t_sts i_sts,
    output ll1_pkg::t_cmd o_cmd,
    output logic          o_busy,
    output logic          o_valid,
    output ll1_pkg::t_res o_res
);
    typedef enum logic [7:0] {
        S_IDLE  = 8'b0000_0001,
        S_DEC   = 8'b0000_0010,
        S_TOP   = 8'b0000_0100,
        S_EVAL  = 8'b0000_1000,
        S_LOOK  = 8'b0001_0000,
        S_CHK   = 8'b0010_0000,
        S_PUSH  = 8'b0100_0000,
        S_REJ   = 8'b1000_0000
    } t_state;

    t_state        r_state, n_state;
    logic          r_valid, n_valid;
    ll1_pkg::t_res r_res, n_res;

    assign o_busy  = (r_state != S_IDLE) || i_sts.clearing;
    assign o_valid = r_valid;
    assign o_res   = r_res;

    always_comb begin
        n_state = r_state;
        n_valid = 1'b0;
        n_res   = '{kind: ll1_pkg::K_DONE, used_production: 8'd0, last: 1'b1};
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_start && !i_sts.clearing) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_DEC;
                end
            end
            S_DEC: begin
                o_cmd.clr_exp = 1'b1;
                if (i_sts.is_token && i_sts.active) begin
                    n_state = S_TOP;
                end else begin
                    n_valid  = 1'b1;
                    n_res.kind = i_sts.is_token ? ll1_pkg::K_ERROR : ll1_pkg::K_DONE;
                    n_state  = S_IDLE;
                end
            end
            S_TOP: begin
                if (i_sts.empty) begin
                    n_valid    = 1'b1;
                    n_res.kind = i_sts.is_end ? ll1_pkg::K_ACCEPT : ll1_pkg::K_ERROR;
                    o_cmd.end_parse = i_sts.is_end;
                    n_state    = S_IDLE;
                end else begin
                    o_cmd.rd_top = 1'b1;
                    n_state = S_LOOK;
                end
            end
            S_LOOK: begin
                o_cmd.rd_cell = 1'b1;
                n_state = S_EVAL;
            end
            S_EVAL: begin
                n_state = S_IDLE;
                o_cmd.end_parse = i_sts.is_end;
                if (i_sts.top_term) begin
                    n_valid = 1'b1;
                    if (i_sts.is_end) n_res.kind = ll1_pkg::K_REJECT;
                    else if (i_sts.top_match) begin
                        n_res.kind = ll1_pkg::K_MATCHED;
                        o_cmd.pop  = 1'b1;
                    end else n_res.kind = ll1_pkg::K_ERROR;
                end else if (!i_sts.hit) begin
                    n_valid    = 1'b1;
                    o_cmd.pop  = 1'b1;
                    n_res.kind = i_sts.is_end ? ll1_pkg::K_REJECT : ll1_pkg::K_ERROR;
                end else begin
                    o_cmd.end_parse = 1'b0;
                    o_cmd.rd_len    = 1'b1;
                    n_state         = S_CHK;
                end
            end
            S_CHK: begin
                if (i_sts.limit) begin
                    n_valid    = 1'b1;
                    n_res.kind = ll1_pkg::K_ERROR;
                    n_res.last = ~i_sts.is_end;
                    o_cmd.end_parse = i_sts.is_end;
                    n_state    = i_sts.is_end ? S_REJ : S_IDLE;
                end else begin
                    o_cmd.exp_begin = 1'b1;
                    n_valid    = 1'b1;
                    n_res      = '{kind: ll1_pkg::K_EXPANDED,
                                   used_production: i_sts.prod, last: 1'b0};
                    n_state    = S_PUSH;
                end
            end
            S_PUSH: begin
                if (i_sts.push_done) n_state = S_TOP;
                else o_cmd.push = 1'b1;
            end
            S_REJ: begin
                n_valid    = 1'b1;
                n_res.kind = ll1_pkg::K_REJECT;
                n_state    = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
        if (r_state == S_DEC && !(i_sts.is_token && i_sts.active)) begin
            o_cmd.wr_table = (i_op == ll1_pkg::OP_TABLE);
            o_cmd.wr_psym  = (i_op == ll1_pkg::OP_PSYM);
            o_cmd.wr_plen  = (i_op == ll1_pkg::OP_PLEN);
            o_cmd.start    = (i_op == ll1_pkg::OP_START);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_valid <= n_valid;
        end
        r_res <= n_res;
    end
endmodule

FILE: rtl/core/ll1_predictive_parse_engine.sv
// ----------------------------------------------------------------------------
// ll1_predictive_parse_engine
// Table-driven LL(1) parser: table and production loads, start, tokens.
// ----------------------------------------------------------------------------
// A request is taken when start is high and busy low. After reset busy stays
// high while the parse table (NONTERMINAL_COUNT by TERMINAL_COUNT cells, each
// capped at 64, so 4096 by default) is cleared one cell a cycle. Loads and
// start give one done result. A token is decoded, then the stack top is read
// with its table cell and evaluated; an expansion reads the production
// length, checks the limits and pushes the symbols. An overflow or expansion
// limit error ends the token, followed by a reject on the end token. The
// sequencer does one stack access a cycle. Results appear for one cycle on
// o_valid and cannot be stalled; last marks the final result of a request.
module ll1_predictive_parse_engine #(
    parameter int STACK_DEPTH       = ll1_pkg::STACK_DEPTH_D,
    parameter int TERMINAL_COUNT    = ll1_pkg::TERMINAL_COUNT_D,
    parameter int NONTERMINAL_COUNT = ll1_pkg::NONTERMINAL_COUNT_D,
    parameter int PRODUCTION_COUNT  = ll1_pkg::PRODUCTION_COUNT_D,
    parameter int MAX_PROD_LEN      = ll1_pkg::MAX_PROD_LEN_D
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          start,
    output logic          busy,
    input  ll1_pkg::t_req i_req,
    output logic          o_valid,
    output ll1_pkg::t_res o_res,
    input  logic          psel,
    input  logic          penable,
    input  logic          pwrite,
    input  logic [1:0]    paddr,
    input  logic [31:0]   pwdata,
    output logic [31:0]   prdata,
    output logic          pready
);
    logic [6:0]    r_start_symbol;
    ll1_pkg::t_cmd w_cmd;
    ll1_pkg::t_sts w_sts;
    logic [2:0]    r_op;

    assign pready = 1'b1;
    assign prdata = (paddr == 2'd0) ? {25'd0, r_start_symbol} : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_start_symbol <= ll1_pkg::START_SYMBOL_RST;
        else if (psel && penable && pwrite && paddr == 2'd0)
            r_start_symbol <= pwdata[6:0];
        if (start && !busy) r_op <= i_req.operation;
    end

    ll1_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_op    (r_op),
        .i_sts   (w_sts),
        .o_cmd   (w_cmd),
        .o_busy  (busy),
        .o_valid (o_valid),
        .o_res   (o_res)
    );

    ll1_datapath #(
        .STACK_DEPTH       (STACK_DEPTH),
        .TERMINAL_COUNT    (TERMINAL_COUNT),
        .NONTERMINAL_COUNT (NONTERMINAL_COUNT),
        .PRODUCTION_COUNT  (PRODUCTION_COUNT),
        .MAX_PROD_LEN      (MAX_PROD_LEN)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_req          (i_req),
        .i_start_symbol (r_start_symbol),
        .i_cmd          (w_cmd),
        .o_sts          (w_sts)
    );
endmodule

FILE: sim/ll1_parse_checker.sv
// ----------------------------------------------------------------------------
// ll1_parse_checker
// Watches the request, result and register channels of the parse engine,
// predicts every result from its own copy of table, productions and stack,
// and compares each result with the oldest one outstanding.
// ----------------------------------------------------------------------------
module ll1_parse_checker (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  logic          i_busy,
    input  ll1_pkg::t_req i_req,
    input  logic          i_valid,
    input  ll1_pkg::t_res i_res,
    input  logic          i_psel,
    input  logic          i_penable,
    input  logic          i_pwrite,
    input  logic [1:0]    i_paddr,
    input  logic [31:0]   i_pwdata,
    input  logic          i_pready,
    output int            o_fail_count,
    output int            o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [1:0] ADDR_START_SYMBOL = 2'd0;

    logic [6:0]    start_sym;
    logic [6:0]    sym_stack [ll1_pkg::STACK_DEPTH_D];
    int            sp;
    logic          active;
    logic [8:0]    cells [ll1_pkg::NONTERMINAL_COUNT_D * ll1_pkg::TERMINAL_COUNT_D];
    logic [6:0]    prod_syms [ll1_pkg::PRODUCTION_COUNT_D * ll1_pkg::MAX_PROD_LEN_D];
    logic [3:0]    prod_lens [ll1_pkg::PRODUCTION_COUNT_D];
    ll1_pkg::t_res expected_q [$];
    int            fails;

    task automatic note(ref ll1_pkg::t_res batch [$], input logic [2:0] k,
                        input logic [7:0] p);
        ll1_pkg::t_res r;
        r.kind = k;
        r.used_production = p;
        r.last = 1'b0;
        batch.insert(batch.size(), r);
    endtask

    task automatic predict_request(input ll1_pkg::t_req r);
        ll1_pkg::t_res batch [$];
        int            n_exp;
        int            plen;
        logic [6:0]    top;
        logic [8:0]    entry;
        logic [7:0]    prod;
        n_exp = 0;
        case (r.operation)
            ll1_pkg::OP_TABLE: begin
                cells[{r.nonterminal_index, r.terminal_code}] =
                    r.entry_valid ? {1'b1, r.production_index} : 9'd0;
                note(batch, ll1_pkg::K_DONE, 8'd0);
            end
            ll1_pkg::OP_PSYM: begin
                prod_syms[{r.production_index, r.position}] = r.symbol_code;
                note(batch, ll1_pkg::K_DONE, 8'd0);
            end
            ll1_pkg::OP_PLEN: begin
                prod_lens[r.production_index] = (r.length > ll1_pkg::MAX_PROD_LEN_D) ?
                    4'(ll1_pkg::MAX_PROD_LEN_D) : r.length;
                note(batch, ll1_pkg::K_DONE, 8'd0);
            end
            ll1_pkg::OP_START: begin
                sym_stack[0] = start_sym;
                sp = 1;
                active = 1'b1;
                note(batch, ll1_pkg::K_DONE, 8'd0);
            end
            ll1_pkg::OP_TOKEN: begin
                if (!active) begin
                    note(batch, ll1_pkg::K_ERROR, 8'd0);
                end else begin
                    while (1) begin
                        if (sp == 0) begin
                            note(batch, r.token_is_end ? ll1_pkg::K_ACCEPT
                                                       : ll1_pkg::K_ERROR, 8'd0);
                            break;
                        end
                        top = sym_stack[sp - 1];
                        if (!top[6]) begin
                            if (r.token_is_end) begin
                                note(batch, ll1_pkg::K_REJECT, 8'd0);
                            end else if (top[5:0] == r.terminal_code) begin
                                sp--;
                                note(batch, ll1_pkg::K_MATCHED, 8'd0);
                            end else begin
                                note(batch, ll1_pkg::K_ERROR, 8'd0);
                            end
                            break;
                        end
                        entry = cells[{top[5:0], r.terminal_code}];
                        if (!entry[8]) begin
                            sp--;
                            note(batch, r.token_is_end ? ll1_pkg::K_REJECT
                                                       : ll1_pkg::K_ERROR, 8'd0);
                            break;
                        end
                        prod = entry[7:0];
                        plen = prod_lens[prod];
                        if (n_exp >= ll1_pkg::EXPANSION_LIMIT
                                || sp - 1 + plen > ll1_pkg::STACK_DEPTH_D) begin
                            note(batch, ll1_pkg::K_ERROR, 8'd0);
                            if (r.token_is_end)
                                note(batch, ll1_pkg::K_REJECT, 8'd0);
                            break;
                        end
                        sp--;
                        for (int k = plen; k > 0; k--) begin
                            sym_stack[sp] = prod_syms[{prod, 3'(k - 1)}];
                            sp++;
                        end
                        n_exp++;
                        note(batch, ll1_pkg::K_EXPANDED, prod);
                    end
                    if (r.token_is_end)
                        active = 1'b0;
                end
            end
            default: note(batch, ll1_pkg::K_DONE, 8'd0);
        endcase
        batch[batch.size() - 1].last = 1'b1;
        foreach (batch[i])
            expected_q.insert(expected_q.size(), batch[i]);
    endtask

    always @(posedge i_clk) begin
        ll1_pkg::t_res want;
        if (!i_rst_n) begin
            start_sym = ll1_pkg::START_SYMBOL_RST;
            sp = 0;
            active = 1'b0;
            foreach (cells[i])
                cells[i] = 9'd0;
            expected_q.delete();
            fails = 0;
        end else begin
            if (i_psel && i_penable && i_pwrite && i_pready && i_paddr == ADDR_START_SYMBOL)
                start_sym = i_pwdata[6:0];
            if (i_start && !i_busy)
                predict_request(i_req);
            if (i_valid) begin
                if (expected_q.size() == 0) begin
                    $error("result with nothing outstanding: kind %0d", i_res.kind);
                    fails++;
                end else begin
                    want = expected_q.pop_front();
                    if (i_res.kind !== want.kind) begin
                        $error("kind: expected %0d, got %0d", want.kind, i_res.kind);
                        fails++;
                    end
                    if (i_res.used_production !== want.used_production) begin
                        $error("used_production: expected %0d, got %0d",
                               want.used_production, i_res.used_production);
                        fails++;
                    end
                    if (i_res.last !== want.last) begin
                        $error("last: expected %0d, got %0d", want.last, i_res.last);
                        fails++;
                    end
                end
            end
        end
        o_fail_count <= fails;
        o_pending <= expected_q.size();
    end

endmodule

FILE: sim/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Drives the parse engine with directed loads and parses, then random
// grammars with mostly well-formed token streams, idling at random; the
// checker predicts and compares every result.
// ----------------------------------------------------------------------------
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int REQUEST_TARGET = 470;
    localparam int WATCHDOG_LIMIT = 20000;
    localparam int SETTLE_CYCLES  = 20;

    logic          i_clk = 1'b0;
    logic          i_rst_n;
    logic          start;
    logic          busy;
    ll1_pkg::t_req i_req;
    logic          o_valid;
    ll1_pkg::t_res o_res;
    logic          psel;
    logic          penable;
    logic          pwrite;
    logic [1:0]    paddr;
    logic [31:0]   pwdata;
    logic [31:0]   prdata;
    logic          pready;
    int            fail_count;
    int            pending;
    int            sent;
    int            stall_cycles;
    bit            calm;

    // production p may sit in a table cell once its length and symbols are written
    bit            len_set [256];
    int            len_sat [256];
    bit [7:0]      sym_set [256];
    logic [7:0]    phase_prods [4];

    always #1 i_clk = ~i_clk;

    ll1_predictive_parse_engine dut (.*);

    ll1_parse_checker u_checker (
        .i_clk, .i_rst_n, .i_start(start), .i_busy(busy), .i_req, .i_valid(o_valid),
        .i_res(o_res), .i_psel(psel), .i_penable(penable), .i_pwrite(pwrite),
        .i_paddr(paddr), .i_pwdata(pwdata), .i_pready(pready),
        .o_fail_count(fail_count), .o_pending(pending)
    );

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((start && !busy) || o_valid)
                stall_cycles <= 0;
            else
                stall_cycles <= stall_cycles + 1;
            if (stall_cycles >= WATCHDOG_LIMIT) begin
                $display("Testbench completed WITH ERRORS");
                $finish;
            end
        end
    end

    function automatic bit prod_ready(input logic [7:0] p);
        if (!len_set[p])
            return 0;
        for (int k = 0; k < len_sat[p]; k++)
            if (!sym_set[p][k])
                return 0;
        return 1;
    endfunction

    function automatic int written_run(input logic [7:0] p);
        int c;
        c = 0;
        while (c < ll1_pkg::MAX_PROD_LEN_D && sym_set[p][c])
            c++;
        return c;
    endfunction

    function automatic ll1_pkg::t_req noise_fields();
        logic [63:0] raw;
        raw = {$urandom, $urandom};
        return raw[$bits(ll1_pkg::t_req)-1:0];
    endfunction

    task automatic send(input ll1_pkg::t_req r);
        bit ok;
        if (!calm && $urandom_range(0, 99) < 10) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
        // keep the loads legal: cells only name complete productions
        case (r.operation)
            ll1_pkg::OP_TABLE: if (r.entry_valid && !prod_ready(r.production_index))
                r.production_index = 8'd255;
            ll1_pkg::OP_PSYM: sym_set[r.production_index][r.position] = 1'b1;
            ll1_pkg::OP_PLEN: begin
                if ((r.length > ll1_pkg::MAX_PROD_LEN_D ? ll1_pkg::MAX_PROD_LEN_D : r.length)
                        > written_run(r.production_index))
                    r.length = 4'(written_run(r.production_index));
                len_set[r.production_index] = 1'b1;
                len_sat[r.production_index] =
                    r.length > ll1_pkg::MAX_PROD_LEN_D ? ll1_pkg::MAX_PROD_LEN_D : r.length;
            end
            default: ;
        endcase
        start <= 1'b1;
        i_req <= r;
        do begin
            @(negedge i_clk);
            ok = !busy;
            @(posedge i_clk);
        end while (!ok);
        sent++;
    endtask

    task automatic send_op(input logic [2:0] op, input logic [5:0] nt, input logic [5:0] tc,
                           input logic [7:0] pi, input logic ev, input logic [2:0] pos,
                           input logic [6:0] sc, input logic [3:0] len, input logic eot);
        ll1_pkg::t_req r;
        r = '{op, nt, tc, pi, ev, pos, sc, len, eot};
        send(r);
    endtask

    task automatic send_token(input logic [5:0] tc, input logic eot);
        ll1_pkg::t_req r;
        r = noise_fields();
        r.operation = ll1_pkg::OP_TOKEN;
        r.terminal_code = tc;
        r.token_is_end = eot;
        send(r);
    endtask

    task automatic settle_and_configure(input logic [6:0] sym);
        start <= 1'b0;
        repeat (2) @(posedge i_clk);
        wait (pending == 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        psel <= 1'b1;
        pwrite <= 1'b1;
        paddr <= 2'd0;
        pwdata <= {$urandom_range(0, 1) ? 25'h1ffffff : 25'd0, sym};
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic load_production(input logic [7:0] p, input int nt_base, input int t_base);
        int            lf;
        int            n;
        ll1_pkg::t_req r;
        lf = $urandom_range(0, 99);
        lf = lf < 10 ? 0 : lf < 80 ? $urandom_range(1, 4) : lf < 95 ? $urandom_range(5, 8)
                        : $urandom_range(9, 15);
        n = lf > ll1_pkg::MAX_PROD_LEN_D ? ll1_pkg::MAX_PROD_LEN_D : lf;
        for (int k = 0; k < n; k++) begin
            r = noise_fields();
            r.operation = ll1_pkg::OP_PSYM;
            r.production_index = p;
            r.position = 3'(k);
            r.symbol_code = ($urandom_range(0, 99) < 65) ? 7'(t_base + $urandom_range(0, 3))
                                                           : 7'(64 + nt_base + $urandom_range(0, 3));
            send(r);
        end
        r = noise_fields();
        r.operation = ll1_pkg::OP_PLEN;
        r.production_index = p;
        r.length = 4'(lf);
        send(r);
    endtask

    task automatic run_phase(input int ph);
        int            nt_base;
        int            t_base;
        int            ntok;
        ll1_pkg::t_req r;
        nt_base = (ph == 0) ? 0 : (ph == 1) ? 60 : $urandom_range(0, 60);
        t_base = (ph == 1) ? 60 : $urandom_range(0, 60);
        settle_and_configure(7'(64 + nt_base));
        foreach (phase_prods[i]) begin
            phase_prods[i] = 8'($urandom_range(0, 255));
            load_production(phase_prods[i], nt_base, t_base);
        end
        for (int row = 0; row < 4; row++) begin
            for (int col = 0; col < 4; col++) begin
                r = noise_fields();
                r.operation = ll1_pkg::OP_TABLE;
                r.nonterminal_index = 6'(nt_base + row);
                r.terminal_code = 6'(t_base + col);
                r.entry_valid = ($urandom_range(0, 99) < 75);
                r.production_index = phase_prods[$urandom_range(0, 3)];
                send(r);
            end
        end
        for (int n = 0; n < 2; n++) begin
            r = noise_fields();
            r.operation = ll1_pkg::OP_START;
            send(r);
            ntok = $urandom_range(4, 16);
            for (int k = 0; k < ntok; k++) begin
                if ($urandom_range(0, 99) < 8) begin
                    r = noise_fields();
                    if (r.operation == ll1_pkg::OP_START || r.operation == ll1_pkg::OP_TOKEN)
                        r.operation = ll1_pkg::OP_PSYM;
                    send(r);
                end else begin
                    send_token(($urandom_range(0, 99) < 85) ? 6'(t_base + $urandom_range(0, 3))
                                                            : 6'($urandom_range(0, 63)), 1'b0);
                end
            end
            if ($urandom_range(0, 99) < 90)
                send_token(6'(t_base + $urandom_range(0, 3)), 1'b1);
        end
    endtask

    initial begin
        i_rst_n <= 1'b0;
        start <= 1'b0;
        i_req <= '0;
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        paddr <= 2'd0;
        pwdata <= 32'd0;
        sent = 0;
        stall_cycles = 0;
        calm = 0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        settle_and_configure(7'd127);
        send_token(6'd5, 1'b0);
        send_token(6'd5, 1'b1);
        send_op(3'd5, 6'd0, 6'd0, 8'd0, 1'b0, 3'd0, 7'd0, 4'd0, 1'b0);
        send_op(3'd6, 6'd63, 6'd63, 8'd255, 1'b1, 3'd7, 7'd127, 4'd15, 1'b1);
        send_op(3'd7, 6'd0, 6'd0, 8'd0, 1'b0, 3'd0, 7'd0, 4'd0, 1'b0);
        send_op(ll1_pkg::OP_PSYM, 6'd63, 6'd63, 8'd255, 1'b1, 3'd0, 7'd5, 4'd15, 1'b1);
        send_op(ll1_pkg::OP_PSYM, 6'd0, 6'd0, 8'd255, 1'b0, 3'd7, 7'd127, 4'd0, 1'b0);
        send_op(ll1_pkg::OP_PLEN, 6'd0, 6'd0, 8'd255, 1'b0, 3'd0, 7'd0, 4'd1, 1'b0);
        send_op(ll1_pkg::OP_TABLE, 6'd63, 6'd5, 8'd255, 1'b1, 3'd0, 7'd0, 4'd0, 1'b0);
        send_op(ll1_pkg::OP_TABLE, 6'd63, 6'd63, 8'd255, 1'b0, 3'd0, 7'd0, 4'd0, 1'b0);
        send_op(ll1_pkg::OP_START, 6'd0, 6'd0, 8'd0, 1'b0, 3'd0, 7'd0, 4'd0, 1'b0);
        send_token(6'd5, 1'b0);
        send_token(6'd5, 1'b0);
        send_token(6'd5, 1'b1);
        send_op(ll1_pkg::OP_START, 6'd0, 6'd0, 8'd0, 1'b0, 3'd0, 7'd0, 4'd0, 1'b0);
        send_token(6'd63, 1'b0);
        send_token(6'd0, 1'b1);
        send_op(ll1_pkg::OP_START, 6'd0, 6'd0, 8'd0, 1'b0, 3'd0, 7'd0, 4'd0, 1'b0);
        send_token(6'd5, 1'b1);

        for (int ph = 0; sent < REQUEST_TARGET; ph++) begin
            calm = (ph == 3);
            run_phase(ph);
        end

        start <= 1'b0;
        repeat (2) @(posedge i_clk);
        wait (pending == 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (fail_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
